// ----- design/pf_pkg.sv -----
// ----------------------------------------------------------------------------
// pf_pkg: shared types for the prime factorizer
// Command and status groups between the controller and the datapath, and the
// codes that select the source of a result item.
// ----------------------------------------------------------------------------
package pf_pkg;

  typedef logic [1:0] osel_t;

  localparam osel_t OSEL_ZERO = 2'd0;
  localparam osel_t OSEL_PEND = 2'd1;
  localparam osel_t OSEL_REM  = 2'd2;

  typedef struct packed {
    logic  load;
    logic  sq;
    logic  div_start;
    logic  div_step;
    logic  rem_update;
    logic  d_step;
    logic  out_load;
    osel_t osel;
    logic  out_last;
    logic  out_nf;
  } pf_cmd_t;

  typedef struct packed {
    logic rem_gt1;
    logic sq_gt;
    logic div_last;
    logic div_zero;
  } pf_sts_t;

endpackage

// ----- design/pf_datapath.sv -----
// ----------------------------------------------------------------------------
// pf_datapath: remainder, candidate divisor, squarer and serial divider
// Holds the arithmetic state and the result register; acts only on commands.
// ----------------------------------------------------------------------------
module pf_datapath import pf_pkg::*; #(
  parameter int VALUE_BITS = 32
) (
  input  logic        clk,
  input  pf_cmd_t     cmd,
  output pf_sts_t     sts,
  input  logic [31:0] in_value,
  output logic [31:0] out_factor,
  output logic        out_last,
  output logic        out_no_factors
);

  localparam int RW = (VALUE_BITS < 32) ? VALUE_BITS : 32;
  localparam int DW = RW / 2 + 2;
  localparam int PW = DW + 1;
  localparam int SW = 2 * DW;
  localparam int CW = $clog2(RW + 1);

  logic [RW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] d_r, d_nxt;
  logic [SW-1:0] sq_r, sq_nxt;
  logic [PW-1:0] p_r, p_nxt;
  logic [RW-1:0] q_r, q_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [DW-1:0] pend_r, pend_nxt;
  logic [31:0]   fac_r, fac_nxt;
  logic          last_r, last_nxt;
  logic          nf_r, nf_nxt;

  logic [PW-1:0] trial;
  logic          fits;

  assign trial = {p_r[PW-2:0], q_r[RW-1]};
  assign fits  = trial >= {1'b0, d_r};

  always_comb begin
    rem_nxt  = rem_r;
    d_nxt    = d_r;
    sq_nxt   = sq_r;
    p_nxt    = p_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    pend_nxt = pend_r;
    fac_nxt  = fac_r;
    last_nxt = last_r;
    nf_nxt   = nf_r;

    if (cmd.load) begin
      rem_nxt = in_value[RW-1:0];
      d_nxt   = DW'(2);
    end
    if (cmd.sq) begin
      sq_nxt = SW'(d_r) * SW'(d_r);
    end
    if (cmd.div_start) begin
      p_nxt   = '0;
      q_nxt   = rem_r;
      cnt_nxt = CW'(RW);
    end
    if (cmd.div_step) begin
      p_nxt   = fits ? (trial - {1'b0, d_r}) : trial;
      q_nxt   = {q_r[RW-2:0], fits};
      cnt_nxt = cnt_r - CW'(1);
    end
    if (cmd.rem_update) begin
      rem_nxt  = q_r;
      pend_nxt = d_r;
    end
    if (cmd.d_step) begin
      d_nxt = (d_r == DW'(2)) ? DW'(3) : d_r + DW'(2);
    end
    if (cmd.out_load) begin
      last_nxt = cmd.out_last;
      nf_nxt   = cmd.out_nf;
      unique case (cmd.osel)
        OSEL_PEND: fac_nxt = 32'(pend_r);
        OSEL_REM:  fac_nxt = 32'(rem_r);
        default:   fac_nxt = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    d_r    <= d_nxt;
    sq_r   <= sq_nxt;
    p_r    <= p_nxt;
    q_r    <= q_nxt;
    cnt_r  <= cnt_nxt;
    pend_r <= pend_nxt;
    fac_r  <= fac_nxt;
    last_r <= last_nxt;
    nf_r   <= nf_nxt;
  end

  assign sts.rem_gt1  = rem_r > RW'(1);
  assign sts.sq_gt    = sq_r > SW'(rem_r);
  assign sts.div_last = cnt_r == CW'(1);
  assign sts.div_zero = p_r == '0;

  assign out_factor     = fac_r;
  assign out_last       = last_r;
  assign out_no_factors = nf_r;

endmodule

// ----- design/pf_ctrl.sv -----
// ----------------------------------------------------------------------------
// pf_ctrl: sequencer of the prime factorizer
// Steps through square, compare and divide for each candidate and hands
// factors to the result register, holding the newest one back until it is
// known whether it is the final factor.
// ----------------------------------------------------------------------------
module pf_ctrl import pf_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  input  pf_sts_t sts,
  output pf_cmd_t cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SQ    = 4'd1;
  localparam logic [3:0] S_TEST  = 4'd2;
  localparam logic [3:0] S_DIV   = 4'd3;
  localparam logic [3:0] S_CHK   = 4'd4;
  localparam logic [3:0] S_EMITP = 4'd5;
  localparam logic [3:0] S_FIN1  = 4'd6;
  localparam logic [3:0] S_FIN2  = 4'd7;
  localparam logic [3:0] S_SMALL = 4'd8;

  logic [3:0] state_r, state_nxt;
  logic       pend_v_r, pend_v_nxt;
  logic       oval_r, oval_nxt;
  logic       out_free;

  assign out_free = !oval_r || !out_stall;

  always_comb begin
    state_nxt  = state_r;
    pend_v_nxt = pend_v_r;
    cmd        = '0;
    cmd.osel   = OSEL_ZERO;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          pend_v_nxt = 1'b0;
          state_nxt  = S_SQ;
        end
      end
      S_SQ: begin
        cmd.sq    = 1'b1;
        state_nxt = sts.rem_gt1 ? S_TEST : S_SMALL;
      end
      S_TEST: begin
        if (sts.sq_gt) begin
          state_nxt = (sts.rem_gt1 && !pend_v_r) ? S_FIN2 : S_FIN1;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        if (!sts.div_zero) begin
          cmd.d_step = 1'b1;
          state_nxt  = S_SQ;
        end else if (pend_v_r) begin
          state_nxt = S_EMITP;
        end else begin
          cmd.rem_update = 1'b1;
          pend_v_nxt     = 1'b1;
          state_nxt      = S_SQ;
        end
      end
      S_EMITP: begin
        if (out_free) begin
          cmd.out_load   = 1'b1;
          cmd.osel       = OSEL_PEND;
          cmd.rem_update = 1'b1;
          state_nxt      = S_SQ;
        end
      end
      S_FIN1: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          cmd.osel     = OSEL_PEND;
          cmd.out_last = !sts.rem_gt1;
          pend_v_nxt   = 1'b0;
          state_nxt    = sts.rem_gt1 ? S_FIN2 : S_IDLE;
        end
      end
      S_FIN2: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          cmd.osel     = OSEL_REM;
          cmd.out_last = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_SMALL: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          cmd.osel     = OSEL_ZERO;
          cmd.out_last = 1'b1;
          cmd.out_nf   = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cmd.out_load) begin
      oval_nxt = 1'b1;
    end else if (!out_stall) begin
      oval_nxt = 1'b0;
    end else begin
      oval_nxt = oval_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      pend_v_r <= 1'b0;
      oval_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      pend_v_r <= pend_v_nxt;
      oval_r   <= oval_nxt;
    end
  end

  assign in_stall  = state_r != S_IDLE;
  assign out_valid = oval_r;

endmodule

// ----- design/prime_factorizer.sv -----
// Throughput: one item at a time; the bit-serial divider (one quotient bit per
// cycle, RW = min(VALUE_BITS, 32) bits) divides by each trial candidate whose
// square does not exceed the remainder. Inputs below 2 skip the search.
// Reset: synchronous, active low; clears the sequencer and the result valid,
// and the block can take an item as soon as reset is released.
// ----------------------------------------------------------------------------
// prime_factorizer: trial-division prime factorization
// Splits each input into its prime factors, ascending, one result item per
// factor, with the last mark on the final one of each input.
// ----------------------------------------------------------------------------
module prime_factorizer import pf_pkg::*; #(
  parameter int VALUE_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_factor,
  output logic        out_last,
  output logic        out_no_factors
);

  // The controller walks candidates 2, 3, 5, 7, ... For each one the
  // datapath first squares the candidate into a register, the controller
  // compares it with the remainder, and if the square does not exceed the
  // remainder a restoring divider runs one quotient bit per cycle. A zero
  // remainder of that division means the candidate is a factor: the
  // quotient replaces the remainder and the same candidate is tried again.
  //
  // A factor found by division is held back in a pending register until the
  // next factor arrives or the search ends, because only then is it known
  // whether it carries the last mark. When the search ends with a remainder
  // above one, that remainder is prime and becomes the final item.
  //
  // Results go through a single output register; the sequencer only waits
  // on it when it has a new item to hand over while the old one is stalled.

  pf_cmd_t cmd;
  pf_sts_t sts;

  pf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  pf_datapath #(
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk            (clk),
    .cmd            (cmd),
    .sts            (sts),
    .in_value       (in_value),
    .out_factor     (out_factor),
    .out_last       (out_last),
    .out_no_factors (out_no_factors)
  );

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench for the prime factorizer
// Feeds integers through the valid/stall input channel, works out their prime
// factors with its own trial division, and checks every result item in order.
// ----------------------------------------------------------------------------
module tb;

  // A 32-bit value has at most 31 prime factors; the prediction caps a run at 32.
  localparam int MAX_FACTOR_ITEMS = 32;
  // Slow cases are kept in the directed part, so the full run stays far below
  // this; it only guards against a hung block.
  localparam int CYCLE_LIMIT = 20000000;
  localparam int DRAIN_CYCLES = 200;
  localparam int LONG_HOLD_CYCLES = 400;

  // One expected result item: a factor and its two flags.
  typedef struct packed {
    logic [31:0] factor;
    logic        last;
    logic        no_factors;
  } factor_item_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] in_value;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_factor;
  logic        out_last;
  logic        out_no_factors;

  // Factors still owed by the block, oldest first.
  factor_item_t pending_factors[$];

  int error_count = 0;
  int values_sent = 0;
  int factors_checked = 0;
  int cycle_count = 0;
  int blocked_cycles = 0;
  bit hold_request;
  bit hold_done;
  int hold_left;
  int burst_left;
  bit idling_on;

  prime_factorizer dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_factor    (out_factor),
    .out_last      (out_last),
    .out_no_factors(out_no_factors)
  );

  // 10 ns clock period.
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Appends one item to the owed list.
  task automatic owe_item(input factor_item_t item);
    pending_factors.insert(pending_factors.size(), item);
  endtask

  // Trial division, as the block does it: candidates 2, 3, 5, 7, ... while the
  // candidate squared does not pass the remainder. Whatever is left above one
  // is a prime factor of its own. The last item of a value is only known once
  // the search is over, so each factor is held back one step before it is
  // queued, and the one still held at the end gets the last mark.
  task automatic predict_factors(input logic [31:0] value);
    logic [63:0]  rest;
    logic [63:0]  cand;
    factor_item_t held;
    bit           have_held;
    int           count;
    rest = {32'd0, value};
    cand = 64'd2;
    count = 0;
    have_held = 1'b0;
    held = '0;
    if (rest < 64'd2) begin
      // Zero and one have no prime factors: a single flagged item.
      held.factor = 32'd0;
      held.last = 1'b1;
      held.no_factors = 1'b1;
      owe_item(held);
    end else begin
      while (cand * cand <= rest) begin
        if (rest % cand == 64'd0) begin
          rest = rest / cand;
          if (count < MAX_FACTOR_ITEMS) begin
            if (have_held)
              owe_item(held);
            held.factor = cand[31:0];
            held.last = 1'b0;
            held.no_factors = 1'b0;
            have_held = 1'b1;
            count++;
          end
        end else begin
          cand = (cand == 64'd2) ? 64'd3 : cand + 64'd2;
        end
      end
      if (rest > 64'd1 && count < MAX_FACTOR_ITEMS) begin
        if (have_held)
          owe_item(held);
        held.factor = rest[31:0];
        held.last = 1'b0;
        held.no_factors = 1'b0;
        have_held = 1'b1;
      end
      held.last = 1'b1;
      owe_item(held);
    end
  endtask

  // Offers one item and waits until the block takes it. While idling is on,
  // valid may first be lowered at random before the item is offered. Valid
  // stays high after acceptance, so back-to-back items need no gap.
  task automatic send_value(input logic [31:0] value);
    int gap;
    if (idling_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      @(negedge clk);
      in_valid = 1'b0;
      in_value = $urandom;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid = 1'b1;
    in_value = value;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
    predict_factors(value);
    values_sent++;
  endtask

  // Lowers valid and waits until every owed factor has come out.
  task automatic wait_for_drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_factors.size() != 0)
      @(posedge clk);
  endtask

  // Picks a value whose factorization stays cheap for the bit-serial divider,
  // while still reaching every bit of the input field.
  function automatic logic [31:0] pick_cheap_value();
    logic [63:0] acc;
    logic [63:0] prime_ish;
    int          kind;
    kind = $urandom_range(0, 99);
    if (kind < 55) begin
      // Product of small numbers: every factor stays below a few hundred,
      // and the products reach into the top bits.
      acc = 64'd1;
      prime_ish = 64'($urandom_range(2, 300));
      while (acc * prime_ish <= 64'hFFFF_FFFF) begin
        acc = acc * prime_ish;
        if ($urandom_range(0, 9) == 0)
          break;
        prime_ish = 64'($urandom_range(2, 300));
      end
      return acc[31:0];
    end else if (kind < 80) begin
      // A small value shifted up: powers of two and high single bits.
      return 32'($urandom_range(0, 4095)) << $urandom_range(0, 31);
    end else if (kind < 95) begin
      // Plain values up to about a million, primes among them.
      return $urandom_range(0, 1 << 20);
    end else begin
      // No factors at all.
      return $urandom_range(0, 1);
    end
  endfunction

  // Result sink: stall comes from a long hold when one is requested, from
  // random bursts while idling is on, and is low otherwise. The long hold is
  // counted here, in cycles, independent of the sender.
  initial begin
    out_stall = 1'b0;
    hold_left = 0;
    burst_left = 0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request && !hold_done) begin
        hold_left = LONG_HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        out_stall = 1'b1;
        hold_left--;
      end else if (burst_left > 0) begin
        out_stall = 1'b1;
        burst_left--;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
        out_stall = 1'b1;
        burst_left = $urandom_range(1, 6) - 1;
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  // Checks each accepted result item against the oldest owed factor.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_factors.size() == 0) begin
        $display("%0t: unexpected result item: factor %0d last %0b no_factors %0b",
                 $time, out_factor, out_last, out_no_factors);
        error_count++;
      end else begin
        if (out_factor !== pending_factors[0].factor) begin
          $display("%0t: factor mismatch: expected %0d, actual %0d",
                   $time, pending_factors[0].factor, out_factor);
          error_count++;
        end
        if (out_last !== pending_factors[0].last) begin
          $display("%0t: last mismatch: expected %0b, actual %0b",
                   $time, pending_factors[0].last, out_last);
          error_count++;
        end
        if (out_no_factors !== pending_factors[0].no_factors) begin
          $display("%0t: no_factors mismatch: expected %0b, actual %0b",
                   $time, pending_factors[0].no_factors, out_no_factors);
          error_count++;
        end
        pending_factors.delete(0);
        factors_checked++;
      end
    end
  end

  // Counts cycles in which the block held back an offered item.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_stall)
      blocked_cycles++;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d factors still owed",
               cycle_count, pending_factors.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Field extremes and the special cases: no factors, primes, squares, a
  // value made only of twos, and a few bit patterns with cheap factors.
  task automatic test_directed();
    send_value(32'd0);
    send_value(32'd1);
    send_value(32'd2);
    send_value(32'd3);
    send_value(32'd4);
    send_value(32'd97);
    send_value(32'd25);
    send_value(32'd49);
    send_value(32'hFFFF_FFFF);
    send_value(32'h8000_0000);
    send_value(32'hAAAA_AAAA);
    send_value(32'h5555_5555);
    send_value(32'd3486784401);
    send_value(32'd223092870);
    send_value(32'd16752649);
    send_value(32'd16777213);
    send_value(32'd65537 << 15);
    send_value(32'd196611);
    send_value(32'd0);
    send_value(32'd1);
    wait_for_drain();
  endtask

  // The sink holds off for a long stretch while the sender keeps offering
  // items; the block's output fills and it has to stall its input.
  task automatic test_backpressure();
    @(negedge clk);
    hold_request = 1'b1;
    send_value(32'h8000_0000);
    send_value(32'd360360);
    send_value(32'd1);
    send_value(32'd6);
    send_value(32'hFFFF_FFFF);
    wait_for_drain();
  endtask

  // Random cheap values with idling on both sides.
  task automatic test_random_idling(input int count);
    repeat (count)
      send_value(pick_cheap_value());
    wait_for_drain();
  endtask

  // The last stretch runs flat out: no gaps and no sink stalls.
  task automatic test_random_full_rate(input int count);
    idling_on = 1'b0;
    repeat (count)
      send_value(pick_cheap_value());
    wait_for_drain();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_value = 32'd0;
    hold_request = 1'b0;
    idling_on = 1'b1;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_backpressure();
    test_random_idling(60);
    test_random_full_rate(20);

    // Give a stray extra item time to show up before the verdict.
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Factorized %0d values into %0d checked factor items in %0d cycles.",
             values_sent, factors_checked, cycle_count);
    $display("Input was held back for %0d cycles, including one long output hold.",
             blocked_cycles);
    if (error_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
